// ----- design/kvi_pkg.sv -----
// Package for the keyframe vector interpolator.
// Holds table sizes, codes, state enums and the records passed between modules.
// No dependencies.
`default_nettype none

package kvi_pkg;

   localparam int KEYS      = 64;
   localparam int KEY_AW    = $clog2(KEYS);
   localparam int CNT_W     = $clog2(KEYS + 1);
   localparam int FACT_W    = 18;
   localparam int FRAC_W    = 16;
   localparam int DIV_STEPS = FACT_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   localparam logic signed [FACT_W-1:0] FACT_MAX = 18'sh1FFFF;
   localparam logic signed [FACT_W-1:0] FACT_MIN = 18'sh20000;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_PAST = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef struct packed {
      logic [31:0]      tkey;
      logic [2:0][31:0] vec;
   } key_entry_type;

   typedef struct packed {
      logic               start;
      logic signed [32:0] num;
      logic signed [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic                     sat;
      logic signed [FACT_W-1:0] factor;
   } div_res_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_STEP,
      DV_FINAL
   } div_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ONE_RD,
      ST_ONE_GET,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SEG_RD,
      ST_SEG_GET,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DIFF,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } main_state_type;

endpackage

`default_nettype wire

// ----- design/kvi_if.sv -----
// Request and response channel interfaces of the keyframe vector interpolator.
// Depends on kvi_pkg for field widths.
`default_nettype none

interface kvi_req_if import kvi_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        operation;
   logic [5:0]  key_index;
   logic [31:0] key_time;
   logic signed [31:0] key_x;
   logic signed [31:0] key_y;
   logic signed [31:0] key_z;
   logic [31:0] query_time;

   modport source (output valid, operation, key_index, key_time, key_x, key_y, key_z,
                   query_time, input ready);
   modport sink   (input valid, operation, key_index, key_time, key_x, key_y, key_z,
                   query_time, output ready);
endinterface

interface kvi_rsp_if import kvi_pkg::*; ();
   logic        valid;
   logic        ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [1:0]  status;

   modport source (output valid, out_x, out_y, out_z, status, input ready);
   modport sink   (input valid, out_x, out_y, out_z, status, output ready);
endinterface

`default_nettype wire

// ----- design/kvi_key_ram.sv -----
// Key table: one write port, one read port with registered read data.
// Depends on kvi_pkg for depth and the entry record.
`default_nettype none

module kvi_key_ram import kvi_pkg::*; (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [KEY_AW-1:0] waddr,
   input  wire key_entry_type wdata,
   input  wire logic [KEY_AW-1:0] raddr,
   output key_entry_type      rdata
);

   key_entry_type mem [KEYS];
   key_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/kvi_div.sv -----
// Iterative factor divider: ((num << 16) / den) truncated toward zero and
// clamped to signed Q1.16, one restoring step per cycle. Depends on kvi_pkg.
`default_nettype none

module kvi_div import kvi_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_res_type      res
);

   div_state_type state_ff, state_in;
   logic [48:0]       rem_ff, rem_in;
   logic [49:0]       dsh_ff, dsh_in;
   logic [32:0]       dm_ff, dm_in;
   logic [FACT_W-1:0] quo_ff, quo_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              ovf_ff, ovf_in;

   logic [32:0] nm;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      dm_ff   <= dm_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      dm_in    = dm_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      ovf_in   = ovf_ff;
      res      = '0;
      nm       = req.num[32] ? 33'(-req.num) : 33'(req.num);

      unique case (state_ff)
         DV_IDLE: begin
            if (req.start) begin
               rem_in   = {nm[32:0], 16'b0};
               dm_in    = req.den[32] ? 33'(-req.den) : 33'(req.den);
               neg_in   = req.num[32] ^ req.den[32];
               zero_in  = (req.den == '0);
               state_in = DV_CHECK;
            end
         end
         DV_CHECK: begin
            // quotient of 2^18 or more cannot fit the factor
            ovf_in   = ({2'b0, rem_ff} >= {dm_ff, 18'b0});
            dsh_in   = {dm_ff, 17'b0};
            quo_in   = '0;
            cnt_in   = '0;
            state_in = zero_ff ? DV_FINAL : DV_STEP;
         end
         DV_STEP: begin
            if ({1'b0, rem_ff} >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff[48:0];
               quo_in = {quo_ff[FACT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[FACT_W-2:0], 1'b0};
            end
            dsh_in = {1'b0, dsh_ff[49:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
               state_in = DV_FINAL;
            end
         end
         DV_FINAL: begin
            res.done = 1'b1;
            if (zero_ff) begin
               res.factor = '0;
            end else if (!neg_ff) begin
               if (ovf_ff || quo_ff[FACT_W-1]) begin
                  res.sat    = 1'b1;
                  res.factor = FACT_MAX;
               end else begin
                  res.factor = $signed(quo_ff);
               end
            end else begin
               if (ovf_ff || (quo_ff > FACT_W'(1 << (FACT_W - 1)))) begin
                  res.sat    = 1'b1;
                  res.factor = FACT_MIN;
               end else begin
                  res.factor = $signed(FACT_W'(-quo_ff));
               end
            end
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- design/keyframe_vector_interpolator_top.sv -----
// Keyframe vector interpolator top level: key table, search sequencer,
// shared lerp multiplier. Depends on kvi_pkg, kvi_if, kvi_key_ram and kvi_div.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    operation, key_index, key_time, key_x/y/z, query_time
//   rsp      out  valid / ready    out_x, out_y, out_z, status
//   csr      in   csr_we           csr_wdata (key_count)
//
// A load writes the table and goes straight to emit. A query with one key reads
// key 0 and emits it. Other queries read one table entry per key examined by the
// table search, then read the segment start and run the serial divider, then make
// three diff, multiply and add passes through the one multiplier.
// One request is in work at a time; the result register lets the next request
// in while a result still waits. Reset is synchronous; the key table is not
// cleared.
`default_nettype none

module keyframe_vector_interpolator_top import kvi_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   kvi_req_if.sink         req,
   kvi_rsp_if.source       rsp,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata
);

   main_state_type state_ff, state_in;
   logic [6:0]        key_count_ff, key_count_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [KEY_AW-1:0] idx_ff, idx_in;
   logic [31:0]       q_ff, q_in;
   logic [31:0]       t1_ff, t1_in;
   logic [2:0][31:0]  start_ff, start_in;
   logic [2:0][31:0]  end_ff, end_in;
   logic [2:0][31:0]  res_ff, res_in;
   logic [1:0]        status_ff, status_in;
   logic              sat_ff, sat_in;
   logic [1:0]        comp_ff, comp_in;
   logic signed [32:0]       num_ff, num_in;
   logic signed [32:0]       dt_ff, dt_in;
   logic signed [FACT_W-1:0] fact_ff, fact_in;
   logic signed [32:0]       diff_ff, diff_in;
   logic signed [50:0]       prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0][31:0]  rsp_vec_ff, rsp_vec_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic              ram_we;
   logic [KEY_AW-1:0] ram_waddr;
   key_entry_type     ram_wdata;
   logic [KEY_AW-1:0] ram_raddr;
   key_entry_type     ram_rdata;
   div_req_type       div_req;
   div_res_type       div_res;

   logic [CNT_W-1:0]   n_clamp;
   logic signed [35:0] sum;
   logic               emit_ok;

   kvi_key_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   kvi_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.out_x  = $signed(rsp_vec_ff[0]);
   assign rsp.out_y  = $signed(rsp_vec_ff[1]);
   assign rsp.out_z  = $signed(rsp_vec_ff[2]);
   assign rsp.status = rsp_status_ff;

   assign ram_waddr = KEY_AW'(req.key_index);
   assign ram_wdata = '{tkey: req.key_time,
                        vec: {32'(req.key_z), 32'(req.key_y), 32'(req.key_x)}};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_count_ff <= 7'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      q_ff          <= q_in;
      t1_ff         <= t1_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      sat_ff        <= sat_in;
      comp_ff       <= comp_in;
      num_ff        <= num_in;
      dt_ff         <= dt_in;
      fact_ff       <= fact_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      rsp_vec_ff    <= rsp_vec_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      key_count_in  = csr_we ? csr_wdata : key_count_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      q_in          = q_ff;
      t1_in         = t1_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      sat_in        = sat_ff;
      comp_in       = comp_ff;
      num_in        = num_ff;
      dt_in         = dt_ff;
      fact_in       = fact_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_vec_in    = rsp_vec_ff;
      rsp_status_in = rsp_status_ff;
      req.ready     = 1'b0;
      ram_we        = 1'b0;
      ram_raddr     = '0;
      div_req       = '{start: 1'b0, num: num_ff, den: dt_ff};
      emit_ok       = !rsp_valid_ff || rsp.ready;

      if (key_count_ff == '0) begin
         n_clamp = CNT_W'(1);
      end else if (32'(key_count_ff) > 32'(KEYS)) begin
         n_clamp = CNT_W'(KEYS);
      end else begin
         n_clamp = CNT_W'(key_count_ff);
      end

      // floor of the product by 2^16, kept signed
      sum = 36'(signed'(start_ff[comp_ff])) + 36'($signed(prod_ff[50:FRAC_W]));

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               res_in    = '0;
               status_in = STATUS_OK;
               sat_in    = 1'b0;
               idx_in    = '0;
               q_in      = req.query_time;
               n_in      = n_clamp;
               if (req.operation == OP_LOAD) begin
                  // slots past the table are dropped
                  ram_we   = (32'(req.key_index) < 32'(KEYS));
                  state_in = ST_EMIT;
               end else if (n_clamp == CNT_W'(1)) begin
                  state_in = ST_ONE_RD;
               end else begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_ONE_RD: begin
            ram_raddr = '0;
            state_in  = ST_ONE_GET;
         end
         ST_ONE_GET: begin
            res_in   = ram_rdata.vec;
            state_in = ST_EMIT;
         end
         ST_SRCH_RD: begin
            ram_raddr = KEY_AW'(idx_ff + 1'b1);
            state_in  = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (q_ff < ram_rdata.tkey) begin
               t1_in    = ram_rdata.tkey;
               end_in   = ram_rdata.vec;
               state_in = ST_SEG_RD;
            end else if ((CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2) >= (CNT_W + 1)'(n_ff)) begin
               // the entry just read is the last key
               res_in    = ram_rdata.vec;
               status_in = STATUS_PAST;
               state_in  = ST_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         ST_SEG_RD: begin
            ram_raddr = idx_ff;
            state_in  = ST_SEG_GET;
         end
         ST_SEG_GET: begin
            start_in = ram_rdata.vec;
            num_in   = $signed({1'b0, q_ff}) - $signed({1'b0, ram_rdata.tkey});
            dt_in    = $signed({1'b0, t1_ff}) - $signed({1'b0, ram_rdata.tkey});
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               fact_in  = div_res.factor;
               sat_in   = div_res.sat;
               comp_in  = '0;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = 33'(signed'(end_ff[comp_ff])) - 33'(signed'(start_ff[comp_ff]));
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = 51'(fact_ff) * 51'(diff_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (sum > 36'sh07FFFFFFF) begin
               res_in[comp_ff] = 32'h7FFFFFFF;
               sat_in          = 1'b1;
            end else if (sum < -36'sh080000000) begin
               res_in[comp_ff] = 32'h80000000;
               sat_in          = 1'b1;
            end else begin
               res_in[comp_ff] = sum[31:0];
            end
            if (comp_ff == 2'd2) begin
               status_in = (sat_in) ? STATUS_SAT : STATUS_OK;
               state_in  = ST_EMIT;
            end else begin
               comp_in  = comp_ff + 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_EMIT: begin
            // hold until the result register is free
            if (emit_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_vec_in    = res_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request accepted while another is in work");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside of the wait state");

   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_ok) |=> (rsp.valid && state_ff == ST_IDLE))
      else $error("result not presented after emit");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.status <= STATUS_SAT))
      else $error("undefined status code");
`endif

endmodule

`default_nettype wire

// ----- tb/kvi_checker.sv -----
// Response checker for the keyframe vector interpolator: watches the request,
// response and CSR ports, predicts each response and compares it field by field.
// Depends on kvi_pkg and the kvi_req_if / kvi_rsp_if interfaces.

module kvi_checker import kvi_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   kvi_req_if              req_mon,
   kvi_rsp_if              rsp_mon,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata,
   output int              fail_count,
   output int              pending,
   output int              past_hits,
   output int              sat_hits
);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [1:0]         status;
   } vec_answer_type;

   localparam longint OUT_MAX = 64'sd2147483647;
   localparam longint OUT_MIN = -64'sd2147483648;

   // x in vec[0], y in vec[1], z in vec[2]
   key_entry_type  key_tab [KEYS];
   logic [6:0]     key_count_reg;
   vec_answer_type expected_answers [$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      past_hits     = 0;
      sat_hits      = 0;
      key_count_reg = 7'd1;
   end

   // Move one component from a toward b by a Q1.16 factor; floor the product,
   // clamp the sum. Bit 32 of the return flags the clamp.
   function automatic logic [32:0] blend_axis(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input longint factor);
      longint base, delta, sum;
      base  = a;
      delta = longint'(b) - base;
      sum   = base + ((factor * delta) >>> 16);
      if (sum > OUT_MAX) return {1'b1, 32'h7FFF_FFFF};
      if (sum < OUT_MIN) return {1'b1, 32'h8000_0000};
      return {1'b0, sum[31:0]};
   endfunction

   function automatic vec_answer_type predict_query(input logic [31:0] qtime);
      vec_answer_type ans;
      key_entry_type  lo, hi;
      int             n, seg;
      bit             found, clipped;
      longint         t0, t1, num, span, factor;
      logic [32:0]    rx, ry, rz;
      ans = '0;
      n   = key_count_reg;
      if (n < 1) n = 1;
      if (n > KEYS) n = KEYS;
      if (n == 1) begin
         ans.x = key_tab[0].vec[0];
         ans.y = key_tab[0].vec[1];
         ans.z = key_tab[0].vec[2];
         return ans;
      end
      found = 1'b0;
      seg   = 0;
      for (int i = 0; i + 1 < n; i++) begin
         if (!found && qtime < key_tab[i + 1].tkey) begin
            seg   = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         ans.x      = key_tab[n - 1].vec[0];
         ans.y      = key_tab[n - 1].vec[1];
         ans.z      = key_tab[n - 1].vec[2];
         ans.status = STATUS_PAST;
         return ans;
      end
      lo      = key_tab[seg];
      hi      = key_tab[seg + 1];
      t0      = lo.tkey;
      t1      = hi.tkey;
      num     = qtime;
      num     = num - t0;
      span    = t1 - t0;
      clipped = 1'b0;
      factor  = 0;
      // equal key times leave the factor at zero
      if (span != 0) begin
         factor = (num * 65536) / span;
         if (factor > FACT_MAX) begin
            factor  = FACT_MAX;
            clipped = 1'b1;
         end
         if (factor < FACT_MIN) begin
            factor  = FACT_MIN;
            clipped = 1'b1;
         end
      end
      rx = blend_axis(lo.vec[0], hi.vec[0], factor);
      ry = blend_axis(lo.vec[1], hi.vec[1], factor);
      rz = blend_axis(lo.vec[2], hi.vec[2], factor);
      ans.x      = rx[31:0];
      ans.y      = ry[31:0];
      ans.z      = rz[31:0];
      clipped    = clipped | rx[32] | ry[32] | rz[32];
      ans.status = clipped ? STATUS_SAT : STATUS_OK;
      return ans;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      vec_answer_type want;
      if (reset) begin
         expected_answers.delete();
         key_count_reg = 7'd1;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_answers.size() == 0) begin
               $error("response with no request outstanding: x=%h y=%h z=%h status=%0d",
                      rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z, rsp_mon.status);
               fail_count++;
            end else begin
               want = expected_answers.pop_front();
               check_field("out_x", want.x, rsp_mon.out_x);
               check_field("out_y", want.y, rsp_mon.out_y);
               check_field("out_z", want.z, rsp_mon.out_z);
               check_field("status", want.status, rsp_mon.status);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.operation == OP_LOAD) begin
               key_tab[req_mon.key_index].tkey   = req_mon.key_time;
               key_tab[req_mon.key_index].vec[0] = req_mon.key_x;
               key_tab[req_mon.key_index].vec[1] = req_mon.key_y;
               key_tab[req_mon.key_index].vec[2] = req_mon.key_z;
               want = '0;
            end else begin
               want = predict_query(req_mon.query_time);
               if (want.status == STATUS_PAST) past_hits++;
               if (want.status == STATUS_SAT) sat_hits++;
            end
            // append at the tail
            expected_answers.insert(expected_answers.size(), want);
         end
         if (csr_we) key_count_reg = csr_wdata;
      end
      pending = expected_answers.size();
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top for keyframe_vector_interpolator_top: clock, reset, request and
// response pacing, directed and random key tables, and the final verdict.
// Depends on kvi_pkg, kvi_if, the block itself and kvi_checker.

module tb;
   import kvi_pkg::*;

   localparam int          ITEM_TARGET = 1400;
   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam logic [31:0] POS_MAX     = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MAX     = 32'h8000_0000;

   logic          clock;
   logic          reset;
   logic          csr_we;
   logic [6:0]    csr_wdata;
   int            fail_count, pending, past_hits, sat_hits;
   int            send_idle_pct, stall_pct, stall_burst;
   int            cycle_count = 0;
   int            load_total, query_total, settings_total, key_count_now;
   logic [31:0]   tab_time [KEYS];
   bit [KEYS-1:0] written;

   kvi_req_if req_bus ();
   kvi_rsp_if rsp_bus ();

   keyframe_vector_interpolator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   kvi_checker check_u (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .past_hits  (past_hits),
      .sat_hits   (sat_hits)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: random stalls, or a counted hold-off when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_burst > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_burst--;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic push_request(input logic op, input logic [5:0] slot,
                               input logic [31:0] kt, kx, ky, kz, qt);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.key_index  <= slot;
      req_bus.key_time   <= kt;
      req_bus.key_x      <= kx;
      req_bus.key_y      <= ky;
      req_bus.key_z      <= kz;
      req_bus.query_time <= qt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic load_key(input logic [5:0] slot, input logic [31:0] t, x, y, z);
      push_request(OP_LOAD, slot, t, x, y, z, $urandom);
      tab_time[slot] = t;
      written[slot]  = 1'b1;
      load_total++;
   endtask

   task automatic ask(input logic [31:0] qt);
      push_request(OP_QUERY, 6'($urandom_range(0, 63)), $urandom, $urandom, $urandom,
                   $urandom, qt);
      query_total++;
   endtask

   // Drop valid and hold until every request has been answered.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_key_count(input logic [6:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      key_count_now = (value == 0) ? 1 : (value > KEYS) ? KEYS : value;
      settings_total++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0:          return POS_MAX;
         1:          return NEG_MAX;
         2, 3, 4, 5: return $urandom;
         default:    return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      endcase
   endfunction

   initial begin : stimulus
      logic [31:0] t, step, lim, qt;
      logic [31:0] seg_times [KEYS];
      logic [6:0]  setting;
      int          seg_no, n, k, q_count, slot;
      bit          down, ok;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_LOAD;
      req_bus.key_index  = '0;
      req_bus.key_time   = '0;
      req_bus.key_x      = '0;
      req_bus.key_y      = '0;
      req_bus.key_z      = '0;
      req_bus.query_time = '0;
      rsp_bus.ready      = 1'b0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      stall_burst        = 0;
      load_total         = 0;
      query_total        = 0;
      settings_total     = 0;
      key_count_now      = 1;
      written            = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single key: any time returns key 0
      load_key(6'd0, 32'h0001_0000, POS_MAX, NEG_MAX, 32'h0);
      ask(32'h0);
      ask(32'hFFFF_FFFF);
      // a zero count behaves as one key
      set_key_count(7'd0);
      ask(32'h1234_5678);

      // falling key times: factor from a negative span, clipped below t1
      load_key(6'd0, 32'h0005_0000, 32'h0001_0000, 32'hFFFE_0000, 32'h0000_0003);
      load_key(6'd1, 32'h0003_0000, 32'h0004_0000, 32'h0000_8000, 32'h7FFF_0000);
      set_key_count(7'd2);
      ask(32'h0002_0000);
      ask(32'h0001_0000);
      ask(32'h0003_0000);
      ask(32'h0004_0000);
      // equal key times
      load_key(6'd1, 32'h0005_0000, 32'h0009_0000, 32'h0000_0001, 32'h8000_0001);
      ask(32'h0001_0000);

      // full-scale times and components
      load_key(6'd0, 32'h0, POS_MAX, NEG_MAX, 32'h0000_0001);
      load_key(6'd1, 32'hFFFF_FFFF, NEG_MAX, POS_MAX, 32'hFFFF_FFFF);
      load_key(6'd2, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      set_key_count(7'd3);
      ask(32'h8000_0000);
      ask(32'hFFFF_FFFE);
      ask(32'hFFFF_FFFF);
      ask(32'h0);
      // before the first key the factor goes negative
      load_key(6'd0, 32'h4000_0000, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
      ask(32'h0);
      load_key(6'd63, 32'hFFFF_FFFF, POS_MAX, NEG_MAX, 32'h0);

      seg_no = 0;
      while (load_total + query_total < ITEM_TARGET) begin
         case (seg_no)
            0: setting = 7'd127;
            1: setting = 7'd64;
            2: setting = 7'd0;
            3: setting = 7'd1;
            4: setting = 7'd65;
            default: begin
               k = $urandom_range(0, 19);
               if (k == 0)      setting = 7'($urandom_range(65, 127));
               else if (k == 1) setting = 7'($urandom_range(9, 64));
               else if (k == 2) setting = 7'($urandom_range(0, 1));
               else             setting = 7'($urandom_range(2, 8));
            end
         endcase
         case (seg_no % 5)
            1: begin
               send_idle_pct = 67;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 67;
            end
            3: begin
               send_idle_pct = 15;
               stall_pct     = 15;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase

         set_key_count(setting);
         n = key_count_now;

         // build a rising table with the odd repeated or falling time
         t = $urandom >> $urandom_range(0, 31);
         for (int i = 0; i < n; i++) begin
            seg_times[i] = t;
            lim = (32'hFFFF_FFFF - t) / (n - i);
            k   = $urandom_range(0, 19);
            if (k == 0) begin
               step = 0;
            end else begin
               step = $urandom_range(0, lim);
               if (k < 8) step = step >> $urandom_range(4, 24);
            end
            if (k == 1) t = t - $urandom_range(0, t);
            else        t = t + step;
         end

         // stall the response side long enough for the block to back up
         if (seg_no == 5) stall_burst = 300;

         down = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < n; i++) begin
            slot = down ? n - 1 - i : i;
            load_key(6'(slot), seg_times[slot], rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(0, 19) == 0) begin
               ok = 1'b1;
               for (int j = 0; j < n; j++) if (!written[j]) ok = 1'b0;
               if (ok) ask($urandom);
            end
         end

         q_count = $urandom_range(6, 24);
         for (int i = 0; i < q_count; i++) begin
            if (n < KEYS && $urandom_range(0, 11) == 0) begin
               // stray load past the active keys
               load_key(6'($urandom_range(n, KEYS - 1)), $urandom, rand_coord(),
                        rand_coord(), rand_coord());
               continue;
            end
            if (i == q_count / 2 && $urandom_range(0, 3) == 0) wait_idle();
            k = $urandom_range(0, n - 1);
            case ($urandom_range(0, 9))
               0: qt = tab_time[k];
               1: qt = $urandom;
               2: qt = tab_time[0] - $urandom_range(0, 32'h0004_0000);
               3: qt = tab_time[n - 1] + $urandom_range(0, 32'h0004_0000);
               default: begin
                  qt = tab_time[k];
                  if (k + 1 < n && tab_time[k + 1] > tab_time[k])
                     qt = tab_time[k] + $urandom_range(0, tab_time[k + 1] - tab_time[k] - 1);
               end
            endcase
            ask(qt);
         end
         seg_no++;
      end

      wait_idle();
      repeat (200) @(negedge clock);

      $display("Covered %0d key loads and %0d queries over %0d key-count settings.",
               load_total, query_total, settings_total);
      $display("%0d queries ran past the last key, %0d saturated.", past_hits, sat_hits);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
